// ----- hdl/hmb_pkg.sv -----
// Shared types and constants for the histogram binner.
// Used by hmb_divider, hmb_bin_store and multi_axis_histogram_binner_core.
package hmb_pkg;

  // Width of every measured value and range edge (signed Q16.16).
  localparam int VALUE_W    = 32;
  // Widths of the fixed request and result fields.
  localparam int ADDR_IN_W  = 12;
  localparam int STATUS_W   = 2;
  localparam int OUT_CNT_W  = 32;
  localparam int BINS_FLD_W = 5;
  localparam int BCNT_W     = 3 * BINS_FLD_W;
  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic OP_BIN  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_COUNTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_BIN_COUNTS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIST_LOW   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIST_HIGH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_LOW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_HIGH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TWIST_LOW  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TWIST_HIGH = 3'd6;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Command from the sequencer to the bin store.
  typedef struct packed {
    logic read;
    logic incr;
  } hmb_store_cmd_t;

endpackage

// ----- hdl/hmb_divider.sv -----
// Serial restoring divider, one quotient bit per cycle.
// Depends on hmb_pkg for the divisor width.
module hmb_divider #(
  parameter int QUOT_W = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [hmb_pkg::VALUE_W+QUOT_W-1:0]    dividend,
  input  logic [hmb_pkg::VALUE_W-1:0]           divisor,
  output logic                                  done,
  output logic [QUOT_W-1:0]                     quotient
);
  import hmb_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [VALUE_W-1:0] rem_r;
  logic [VALUE_W-1:0] rem_nxt;
  logic [VALUE_W-1:0] div_r;
  logic [QUOT_W-1:0] low_r;
  logic [QUOT_W-1:0] quot_r;
  logic [QUOT_W-1:0] quot_nxt;
  logic [VALUE_W:0]  trial;
  logic [VALUE_W:0]  diff;
  logic              fits;

  // The caller guarantees dividend < divisor * 2^QUOT_W, so the upper part
  // starts below the divisor and the remainder always fits VALUE_W bits.
  always_comb begin
    trial    = {rem_r, low_r[QUOT_W-1]};
    diff     = trial - {1'b0, div_r};
    fits     = !diff[VALUE_W];
    rem_nxt  = fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
    quot_nxt = (quot_r << 1) | QUOT_W'(fits);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend[VALUE_W+QUOT_W-1:QUOT_W];
      low_r  <= dividend[QUOT_W-1:0];
      div_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      low_r  <= low_r << 1;
      quot_r <= quot_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// ----- hdl/hmb_bin_store.sv -----
// Histogram counter memory with saturating read-modify-write and a
// clearing sweep after reset. Depends on hmb_pkg for the command struct.
module hmb_bin_store #(
  parameter int DEPTH   = 4096,
  parameter int COUNT_W = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hmb_pkg::hmb_store_cmd_t     cmd,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  output logic                        clearing,
  output logic                        ack,
  output logic [COUNT_W-1:0]          rdata
);
  import hmb_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  logic [COUNT_W-1:0] mem [DEPTH];
  logic               clearing_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic               ack_r;
  logic               pend_incr_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic [COUNT_W-1:0] rd_data_r;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // The write port serves the clearing sweep and the second half of an
  // increment; both never overlap because no command comes while clearing.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr_r;
    wr_data = rd_data_r + COUNT_W'(1);
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (pend_incr_r && (rd_data_r != '1)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read || cmd.incr) begin
      rd_data_r <= mem[addr];
    end
    pend_addr_r <= addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      ack_r       <= 1'b0;
      pend_incr_r <= 1'b0;
    end else begin
      ack_r       <= cmd.read || cmd.incr;
      pend_incr_r <= cmd.incr;
      if (clearing_r) begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
        end
      end
    end
  end

  assign clearing = clearing_r;
  assign ack      = ack_r;
  assign rdata    = rd_data_r;

endmodule

// ----- hdl/multi_axis_histogram_binner_core.sv -----
// Multi-axis histogram binner: sequencer, configuration registers and
// result register; uses hmb_pkg, hmb_divider and hmb_bin_store.
//
// Requests arrive on the in_ channel (in_valid / in_stall). A bin request
// carries distance, angle and twist values; each active axis (nonzero bin
// count) is range checked and its bin index is found by one shared serial
// divider, one quotient bit per cycle. The packed bin is then incremented
// with a read-modify-write of the counter memory. A read request returns
// one stored bin. Each request gives exactly one result on the out_ channel.
// Timing: the sequencer handles one request at a time. A read passes the
// finish, memory access and done states. A bin request passes select for
// each axis plus check and divide for each active axis, the divider's bit
// steps being the bulk of it, then finish, memory access (when counted) and
// done. A rejected sample stops at the first failing axis.
// Reset clears the registers and then sweeps the counter memory to zero,
// one entry a cycle (MAX_BINS_PER_AXIS^3 entries, 4096 by default); in_stall
// stays high during that sweep while the APB port keeps working.
// The result register decouples the sides: a new request is accepted while
// a result waits under out_stall, and that request's result holds in the
// sequencer until the register frees up.
module multi_axis_histogram_binner_core #(
  parameter int MAX_BINS_PER_AXIS = 16,
  parameter int COUNT_WIDTH       = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic signed [hmb_pkg::VALUE_W-1:0]  in_dist_value,
  input  logic signed [hmb_pkg::VALUE_W-1:0]  in_angle_value,
  input  logic signed [hmb_pkg::VALUE_W-1:0]  in_twist_value,
  input  logic [hmb_pkg::ADDR_IN_W-1:0]       in_bin_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hmb_pkg::STATUS_W-1:0]        out_status,
  output logic [hmb_pkg::OUT_CNT_W-1:0]       out_bin_value,
  output logic [hmb_pkg::OUT_CNT_W-1:0]       out_invalid_total,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hmb_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [hmb_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [hmb_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import hmb_pkg::*;

  localparam int DEPTH  = MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AXIS_W = $clog2(MAX_BINS_PER_AXIS);
  localparam int BINS_W = $clog2(MAX_BINS_PER_AXIS + 1);
  localparam int NUM_W  = VALUE_W + AXIS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SELECT = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIVIDE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_RMW    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [1:0] AXIS_DIST  = 2'd0;
  localparam logic [1:0] AXIS_ANGLE = 2'd1;
  localparam logic [1:0] AXIS_TWIST = 2'd2;
  localparam logic [1:0] AXIS_END   = 2'd3;

  // Configuration registers.
  logic [BCNT_W-1:0] bin_counts_r;
  value_t            dist_low_r;
  value_t            dist_high_r;
  value_t            angle_low_r;
  value_t            angle_high_r;
  value_t            twist_low_r;
  value_t            twist_high_r;
  logic              cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;

  // Latched request.
  logic                 op_r;
  value_t               dist_r;
  value_t               angle_r;
  value_t               twist_r;
  logic [ADDR_IN_W-1:0] rd_addr_r;
  logic                 in_accept;

  // Sequencer state and datapath.
  logic [2:0]          state_r, state_nxt;
  logic [1:0]          axis_r, axis_nxt;
  logic                any_r, any_nxt;
  logic                bad_r, bad_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [BINS_W-1:0]   bins_r, bins_nxt;
  logic signed [VALUE_W:0] diff_r, diff_nxt;
  logic signed [VALUE_W:0] range_r, range_nxt;
  logic [COUNT_WIDTH-1:0]  rej_r, rej_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [COUNT_WIDTH-1:0]  res_value_r, res_value_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0]    out_bin_value_r, out_bin_value_nxt;
  logic [OUT_CNT_W-1:0]    out_invalid_r, out_invalid_nxt;

  // Per-axis selection.
  logic [BINS_FLD_W-1:0] raw_bins;
  logic [BINS_W-1:0]     eff_bins;
  value_t                sel_x;
  value_t                sel_low;
  value_t                sel_high;
  logic                  axis_bad;
  logic                  rd_in_range;

  // Shared units.
  logic                  div_start;
  logic                  div_done;
  logic [AXIS_W-1:0]     div_quot;
  logic [NUM_W-1:0]      div_dividend;
  hmb_store_cmd_t        store_cmd;
  logic [ADDR_W-1:0]     store_addr;
  logic                  store_clearing;
  logic                  store_ack;
  logic [COUNT_WIDTH-1:0] store_rdata;

  // ---------------------------------------------------------------------
  // APB configuration port. Writes land in the access phase; reads are a
  // plain mux, and the register index comes from the word address.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_counts_r <= '0;
      dist_low_r   <= '0;
      dist_high_r  <= '0;
      angle_low_r  <= '0;
      angle_high_r <= '0;
      twist_low_r  <= '0;
      twist_high_r <= '0;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_BIN_COUNTS: bin_counts_r <= pwdata[BCNT_W-1:0];
        REG_DIST_LOW:   dist_low_r   <= pwdata;
        REG_DIST_HIGH:  dist_high_r  <= pwdata;
        REG_ANGLE_LOW:  angle_low_r  <= pwdata;
        REG_ANGLE_HIGH: angle_high_r <= pwdata;
        REG_TWIST_LOW:  twist_low_r  <= pwdata;
        REG_TWIST_HIGH: twist_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BIN_COUNTS: prdata = CFG_DATA_W'(bin_counts_r);
      REG_DIST_LOW:   prdata = dist_low_r;
      REG_DIST_HIGH:  prdata = dist_high_r;
      REG_ANGLE_LOW:  prdata = angle_low_r;
      REG_ANGLE_HIGH: prdata = angle_high_r;
      REG_TWIST_LOW:  prdata = twist_low_r;
      REG_TWIST_HIGH: prdata = twist_high_r;
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request intake. Only the idle sequencer takes a request, and never
  // while the memory is still being swept after reset.
  // ---------------------------------------------------------------------
  assign in_stall  = (state_r != S_IDLE) || store_clearing;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r      <= in_operation;
      dist_r    <= in_dist_value;
      angle_r   <= in_angle_value;
      twist_r   <= in_twist_value;
      rd_addr_r <= in_bin_address;
    end
  end

  // ---------------------------------------------------------------------
  // Axis operand selection. The end code is only acted on in the select state,
  // where it finishes the walk, so its operands do not matter.
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (axis_r)
      AXIS_DIST: begin
        raw_bins = bin_counts_r[BINS_FLD_W-1:0];
        sel_x    = dist_r;
        sel_low  = dist_low_r;
        sel_high = dist_high_r;
      end
      AXIS_ANGLE: begin
        raw_bins = bin_counts_r[2*BINS_FLD_W-1:BINS_FLD_W];
        sel_x    = angle_r;
        sel_low  = angle_low_r;
        sel_high = angle_high_r;
      end
      default: begin
        raw_bins = bin_counts_r[3*BINS_FLD_W-1:2*BINS_FLD_W];
        sel_x    = twist_r;
        sel_low  = twist_low_r;
        sel_high = twist_high_r;
      end
    endcase
  end

  // A bin count above the store's axis size acts as the axis size.
  assign eff_bins = (32'(raw_bins) > 32'(MAX_BINS_PER_AXIS)) ?
                    BINS_W'(MAX_BINS_PER_AXIS) : BINS_W'(raw_bins);

  // The value must lie in [low, high) of a nonempty range. Once both
  // differences are known to be non-negative, the upper check is an
  // unsigned compare of their low bits.
  assign axis_bad = diff_r[VALUE_W] || range_r[VALUE_W] || (range_r == '0) ||
                    (diff_r[VALUE_W-1:0] >= range_r[VALUE_W-1:0]);

  // bins * (x - low) is below bins * (high - low), so the quotient is an
  // index below bins and fits AXIS_W bits.
  assign div_dividend = NUM_W'(NUM_W'(bins_r) * NUM_W'(diff_r[VALUE_W-1:0]));

  assign rd_in_range = 32'(rd_addr_r) < 32'(DEPTH);

  // ---------------------------------------------------------------------
  // Sequencer. Axes are walked in the order distance, angle, twist, so the
  // first active axis ends up most significant in the packed address.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt         = state_r;
    axis_nxt          = axis_r;
    any_nxt           = any_r;
    bad_nxt           = bad_r;
    addr_nxt          = addr_r;
    bins_nxt          = bins_r;
    diff_nxt          = diff_r;
    range_nxt         = range_r;
    rej_nxt           = rej_r;
    res_status_nxt    = res_status_r;
    res_value_nxt     = res_value_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_bin_value_nxt = out_bin_value_r;
    out_invalid_nxt   = out_invalid_r;
    div_start         = 1'b0;
    store_cmd         = '0;
    store_addr        = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          axis_nxt  = AXIS_DIST;
          any_nxt   = 1'b0;
          bad_nxt   = 1'b0;
          addr_nxt  = '0;
          state_nxt = (in_operation == OP_READ) ? S_FINISH : S_SELECT;
        end
      end
      S_SELECT: begin
        if (axis_r == AXIS_END) begin
          state_nxt = S_FINISH;
        end else if (raw_bins == '0) begin
          axis_nxt = axis_r + 2'd1;
        end else begin
          any_nxt   = 1'b1;
          bins_nxt  = eff_bins;
          diff_nxt  = {sel_x[VALUE_W-1], sel_x} - {sel_low[VALUE_W-1], sel_low};
          range_nxt = {sel_high[VALUE_W-1], sel_high} - {sel_low[VALUE_W-1], sel_low};
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (axis_bad) begin
          bad_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          addr_nxt  = ADDR_W'(addr_r * ADDR_W'(MAX_BINS_PER_AXIS)) + ADDR_W'(div_quot);
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_SELECT;
        end
      end
      S_FINISH: begin
        res_value_nxt = '0;
        if (op_r == OP_READ) begin
          store_cmd.read = 1'b1;
          store_addr     = ADDR_W'(rd_addr_r);
          state_nxt      = S_RMW;
        end else if (!any_r) begin
          res_status_nxt = ST_INACTIVE;
          state_nxt      = S_DONE;
        end else if (bad_r) begin
          if (rej_r != '1) begin
            rej_nxt = rej_r + COUNT_WIDTH'(1);
          end
          res_status_nxt = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          store_cmd.incr = 1'b1;
          res_status_nxt = ST_COUNTED;
          state_nxt      = S_RMW;
        end
      end
      S_RMW: begin
        if (store_ack) begin
          if (op_r == OP_READ) begin
            res_status_nxt = ST_READ;
            res_value_nxt  = rd_in_range ? store_rdata : '0;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // The result moves to the output register once it is free or is
        // being taken in this cycle.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = res_status_r;
          out_bin_value_nxt = OUT_CNT_W'(res_value_r);
          out_invalid_nxt   = OUT_CNT_W'(rej_r);
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_DIST;
      any_r       <= 1'b0;
      bad_r       <= 1'b0;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      any_r       <= any_nxt;
      bad_r       <= bad_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r          <= addr_nxt;
    bins_r          <= bins_nxt;
    diff_r          <= diff_nxt;
    range_r         <= range_nxt;
    res_status_r    <= res_status_nxt;
    res_value_r     <= res_value_nxt;
    out_status_r    <= out_status_nxt;
    out_bin_value_r <= out_bin_value_nxt;
    out_invalid_r   <= out_invalid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_bin_value     = out_bin_value_r;
  assign out_invalid_total = out_invalid_r;

  // ---------------------------------------------------------------------
  // Shared divider and counter memory.
  // ---------------------------------------------------------------------
  hmb_divider #(
    .QUOT_W (AXIS_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (range_r[VALUE_W-1:0]),
    .done     (div_done),
    .quotient (div_quot)
  );

  hmb_bin_store #(
    .DEPTH   (DEPTH),
    .COUNT_W (COUNT_WIDTH)
  ) u_bin_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (store_cmd),
    .addr     (store_addr),
    .clearing (store_clearing),
    .ack      (store_ack),
    .rdata    (store_rdata)
  );

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVIDE))
    else $error("divider finished outside the divide state");

  a_store_ack_in_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    store_ack |-> (state_r == S_RMW))
    else $error("bin store answered outside the memory access state");

  a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (store_cmd.read || store_cmd.incr) |-> !store_clearing)
    else $error("bin store command issued during the clearing sweep");

  a_rejected_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (rej_r >= $past(rej_r)))
    else $error("rejected sample counter decreased");

endmodule
